// ===== src/binomial_tail_sum_mod_core_assert.svh =====
// assertion macros used by the port checker of the tail sum core
`ifndef BINOMIAL_TAIL_SUM_MOD_CORE_ASSERT_SVH
`define BINOMIAL_TAIL_SUM_MOD_CORE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define BTSM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tail sum core port property violated");

// next-cycle implication, sampled on aclk, off while in reset
`define BTSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tail sum core port property violated");

`endif

// ===== src/btsm_pkg.sv =====
// types, constants and microcode rom of the binomial tail sum core
`timescale 1ns / 1ps

package btsm_pkg;

    // field widths and bus widths
    localparam int N_W      = 11;
    localparam int K_W      = 11;
    localparam int SUM_W    = 20;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // default largest row
    localparam int DEF_MAX_N = 2047;

    // modulus of all sums
    localparam logic [SUM_W-1:0] TAIL_MOD = 20'd1000000;

    // microprogram addresses
    typedef enum logic [3:0] {
        U_IDLE,
        U_ROW_TOP,
        U_ROW_CHK,
        U_PRIME,
        U_LOOP,
        U_ROW_NEXT,
        U_SUM_INIT,
        U_SUM_LOOP,
        U_DONE
    } upc_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_IN,
        C_I_GT_N,
        C_I_IS_ONE,
        C_PTR_ZERO,
        C_EMPTY,
        C_PTR_EQ_N,
        C_OUT_BUSY
    } cond_t;

    // read port operations, each but RD_NONE also moves the pointer
    typedef enum logic [2:0] {
        RD_NONE,
        RD_I_DEC,
        RD_PTR_DEC,
        RD_PTR_INC,
        RD_K
    } rd_op_t;

    // write port operations
    typedef enum logic [1:0] {
        WR_NONE,
        WR_ZERO_ONE,
        WR_I_ONE,
        WR_SUM
    } wr_op_t;

    // accumulator operations
    typedef enum logic [1:0] {
        ACC_KEEP,
        ACC_CLR,
        ACC_ADD
    } acc_op_t;

    // one control word: wr, acc and hold_ld act on every visit,
    // rd, i_set, i_inc, load and emit only when the jump is not taken
    typedef struct packed {
        cond_t   cond;
        upc_t    jump;
        upc_t    next;
        wr_op_t  wr;
        acc_op_t acc;
        logic    hold_ld;
        rd_op_t  rd;
        logic    i_set;
        logic    i_inc;
        logic    load;
        logic    emit;
    } ctrl_word_t;

    // microcode rom
    function automatic ctrl_word_t ucode_word(upc_t upc);
        ctrl_word_t w;
        w = '{cond: C_NEVER, jump: U_IDLE, next: U_IDLE, wr: WR_NONE, acc: ACC_KEEP,
              hold_ld: 1'b0, rd: RD_NONE, i_set: 1'b0, i_inc: 1'b0, load: 1'b0,
              emit: 1'b0};
        case (upc)
            U_IDLE: begin
                // wait for a request, seed row 0
                w.cond  = C_NO_IN;
                w.jump  = U_IDLE;
                w.next  = U_ROW_TOP;
                w.wr    = WR_ZERO_ONE;
                w.acc   = ACC_CLR;
                w.i_set = 1'b1;
                w.load  = 1'b1;
            end
            U_ROW_TOP: begin
                w.cond = C_I_GT_N;
                w.jump = U_SUM_INIT;
                w.next = U_ROW_CHK;
            end
            U_ROW_CHK: begin
                // new last entry is one, fetch the old last entry
                w.cond = C_I_IS_ONE;
                w.jump = U_ROW_NEXT;
                w.next = U_PRIME;
                w.wr   = WR_I_ONE;
                w.rd   = RD_I_DEC;
            end
            U_PRIME: begin
                w.next    = U_LOOP;
                w.hold_ld = 1'b1;
                w.rd      = RD_PTR_DEC;
            end
            U_LOOP: begin
                // one pascal addition per cycle, walking down the row
                w.cond    = C_PTR_ZERO;
                w.jump    = U_ROW_NEXT;
                w.next    = U_LOOP;
                w.wr      = WR_SUM;
                w.hold_ld = 1'b1;
                w.rd      = RD_PTR_DEC;
            end
            U_ROW_NEXT: begin
                w.next  = U_ROW_TOP;
                w.i_inc = 1'b1;
            end
            U_SUM_INIT: begin
                w.cond = C_EMPTY;
                w.jump = U_DONE;
                w.next = U_SUM_LOOP;
                w.rd   = RD_K;
            end
            U_SUM_LOOP: begin
                // add one entry per cycle, walking up to n
                w.cond = C_PTR_EQ_N;
                w.jump = U_DONE;
                w.next = U_SUM_LOOP;
                w.acc  = ACC_ADD;
                w.rd   = RD_PTR_INC;
            end
            U_DONE: begin
                w.cond = C_OUT_BUSY;
                w.jump = U_DONE;
                w.next = U_IDLE;
                w.emit = 1'b1;
            end
            default: begin
                w.next = U_IDLE;
            end
        endcase
        return w;
    endfunction

    // a + b modulo TAIL_MOD, both operands below the modulus
    function automatic logic [SUM_W-1:0] mod_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, TAIL_MOD}) begin
            s = s - {1'b0, TAIL_MOD};
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

// ===== src/binomial_tail_sum_mod_core.sv =====
// binomial tail sum core: microcoded sequencer over a pascal row memory
`timescale 1ns / 1ps

// Takes a request (n_total, k_min) and returns the sum of C(n_total, k) for
// k = k_min..n_total modulo 1000000, or 0 when k_min exceeds n_total; n_total
// above MAX_N is treated as MAX_N. The core builds row n of pascal's triangle
// modulo 1000000 in an internal single-port-write, single-port-read memory of
// MAX_N+1 entries, then adds up its tail. One request is in flight at a time;
// the last step also waits while an earlier result is still stalled on the
// master side.
// s_tready is high while the core is idle, also while a finished result still
// waits on the master side.
module binomial_tail_sum_mod_core
    import btsm_pkg::*;
#(
    parameter int MAX_N = DEF_MAX_N
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // n_total [10:0], k_min [21:11]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // tail_sum [19:0]
);

    localparam int DEPTH = MAX_N + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(MAX_N + 2);
    localparam int CMP_W = (IDX_W > N_W) ? IDX_W : N_W;
    localparam logic [CMP_W-1:0] MAX_N_CMP = CMP_W'(MAX_N);
    localparam logic [IDX_W-1:0] MAX_N_IDX = IDX_W'(MAX_N);

    // sequencer
    upc_t       upc_reg, upc_next;
    ctrl_word_t cw;
    logic       jump_take;

    // datapath registers
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             empty_reg, empty_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] i_dec;
    logic [SUM_W-1:0] hold_reg, hold_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [SUM_W-1:0] rdata_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [SUM_W-1:0] m_sum_reg, m_sum_next;

    // row memory ports
    logic [SUM_W-1:0] row_mem [DEPTH];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SUM_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // request fields
    logic [N_W-1:0]   n_in;
    logic [K_W-1:0]   k_in;
    logic [IDX_W-1:0] n_clamp;
    logic             empty_in;

    assign n_in  = s_tdata[N_W-1:0];
    assign k_in  = s_tdata[N_W+K_W-1:N_W];
    assign i_dec = i_reg - CNT_W'(1);

    // clamp the row and flag an empty range at load time
    always_comb begin
        if (CMP_W'(n_in) > MAX_N_CMP) begin
            n_clamp = MAX_N_IDX;
        end else begin
            n_clamp = IDX_W'(n_in);
        end
        empty_in = (CMP_W'(k_in) > CMP_W'(n_clamp));
    end

    // fetch the control word and evaluate its jump condition
    always_comb begin
        cw = ucode_word(upc_reg);
        case (cw.cond)
            C_NEVER:    jump_take = 1'b0;
            C_NO_IN:    jump_take = !s_tvalid;
            C_I_GT_N:   jump_take = (i_reg > CNT_W'(n_reg));
            C_I_IS_ONE: jump_take = (i_reg == CNT_W'(1));
            C_PTR_ZERO: jump_take = (ptr_reg == '0);
            C_EMPTY:    jump_take = empty_reg;
            C_PTR_EQ_N: jump_take = (ptr_reg == n_reg);
            C_OUT_BUSY: jump_take = m_tvalid_reg && !m_tready;
            default:    jump_take = 1'b0;
        endcase
    end

    // next step and datapath controls
    always_comb begin
        upc_next      = jump_take ? cw.jump : cw.next;
        n_next        = n_reg;
        k_next        = k_reg;
        empty_next    = empty_reg;
        ptr_next      = ptr_reg;
        i_next        = i_reg;
        hold_next     = hold_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_sum_next    = m_sum_reg;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg + IDX_W'(1);
        wr_data       = mod_add(hold_reg, rdata_reg);
        rd_en         = 1'b0;
        rd_addr       = ptr_reg;

        // write port, acts on every visit
        case (cw.wr)
            WR_NONE: begin
                wr_en = 1'b0;
            end
            WR_ZERO_ONE: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = SUM_W'(1);
            end
            WR_I_ONE: begin
                wr_en   = 1'b1;
                wr_addr = i_reg[IDX_W-1:0];
                wr_data = SUM_W'(1);
            end
            WR_SUM: begin
                wr_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase

        // accumulator and hold, act on every visit
        case (cw.acc)
            ACC_KEEP: acc_next = acc_reg;
            ACC_CLR:  acc_next = '0;
            ACC_ADD:  acc_next = mod_add(acc_reg, rdata_reg);
            default:  acc_next = acc_reg;
        endcase
        if (cw.hold_ld) begin
            hold_next = rdata_reg;
        end

        // addressing, counters and handshakes, only when falling through
        if (!jump_take) begin
            case (cw.rd)
                RD_NONE: begin
                    rd_en = 1'b0;
                end
                RD_I_DEC: begin
                    rd_en    = 1'b1;
                    rd_addr  = i_dec[IDX_W-1:0];
                    ptr_next = i_dec[IDX_W-1:0];
                end
                RD_PTR_DEC: begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg - IDX_W'(1);
                    ptr_next = ptr_reg - IDX_W'(1);
                end
                RD_PTR_INC: begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + IDX_W'(1);
                    ptr_next = ptr_reg + IDX_W'(1);
                end
                RD_K: begin
                    rd_en    = 1'b1;
                    rd_addr  = k_reg;
                    ptr_next = k_reg;
                end
                default: begin
                    rd_en = 1'b0;
                end
            endcase
            if (cw.i_set) begin
                i_next = CNT_W'(1);
            end
            if (cw.i_inc) begin
                i_next = i_reg + CNT_W'(1);
            end
            if (cw.load) begin
                n_next     = n_clamp;
                k_next     = IDX_W'(k_in);
                empty_next = empty_in;
            end
            if (cw.emit) begin
                m_tvalid_next = 1'b1;
                m_sum_next    = acc_reg;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg      <= U_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            upc_reg      <= upc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        k_reg     <= k_next;
        empty_reg <= empty_next;
        ptr_reg   <= ptr_next;
        i_reg     <= i_next;
        hold_reg  <= hold_next;
        acc_reg   <= acc_next;
        m_sum_reg <= m_sum_next;
    end

    // row memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= row_mem[rd_addr];
        end
    end

    assign s_tready = (upc_reg == U_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(m_sum_reg);

endmodule

// ===== src/btsm_check.sv =====
// port checker of the binomial tail sum core and its bind
`timescale 1ns / 1ps
`include "binomial_tail_sum_mod_core_assert.svh"

module btsm_check
    import btsm_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,   // n_total [10:0], k_min [21:11]
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata    // tail_sum [19:0]
);

    // a stalled result holds its value
    `BTSM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // every result is reduced and has clean padding
    `BTSM_ASSERT_SAME(a_out_range, m_tvalid, (m_tdata[M_DATA_W-1:SUM_W] == '0) && (m_tdata[SUM_W-1:0] < TAIL_MOD))

    // a taken request keeps the core busy for the next cycle
    `BTSM_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)

endmodule

bind binomial_tail_sum_mod_core btsm_check u_btsm_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/binomial_tail_sum_mod_core_tb.sv =====
// testbench of the binomial tail sum core: pascal row predictor and stream checker
`timescale 1ns / 1ps

module binomial_tail_sum_mod_core_tb;
    import btsm_pkg::*;

    localparam int     CLK_PERIOD     = 8;
    localparam int     ROW_MAX        = DEF_MAX_N;
    localparam int     MOD_VALUE      = 1000000;
    localparam int     TAIL_CYCLES    = 16;
    localparam longint TIMEOUT_CYCLES = 30_000_000;

    // one accepted request and the sum it should produce
    typedef struct {
        logic [N_W-1:0]   n_total;
        logic [K_W-1:0]   k_min;
        logic [SUM_W-1:0] tail_sum;
    } tail_req_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // n_total [10:0], k_min [21:11]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // tail_sum [19:0]

    tail_req_t expected_sums[$];
    int        error_count  = 0;
    int        src_idle_pct = 14;
    int        dst_idle_pct = 83;

    binomial_tail_sum_mod_core #(
        .MAX_N (ROW_MAX)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAIL binomial_tail_sum_mod_core");
        $finish;
    end

    // predictor: build row n of pascal's triangle mod 1e6, then sum its tail
    function automatic logic [SUM_W-1:0] predict_tail_sum(input logic [N_W-1:0] n_in,
                                                          input logic [K_W-1:0] k_in);
        int pascal [0:ROW_MAX];
        int n;
        int k;
        int s;
        int acc;
        n = n_in;
        k = k_in;
        if (n > ROW_MAX) begin
            n = ROW_MAX;
        end
        pascal[0] = 1;
        for (int i = 1; i <= n; i++) begin
            pascal[i] = 1;
            for (int j = i - 1; j >= 1; j--) begin
                s = pascal[j] + pascal[j-1];
                pascal[j] = (s >= MOD_VALUE) ? s - MOD_VALUE : s;
            end
        end
        acc = 0;
        // empty range leaves the sum at zero
        for (int j = k; j <= n; j++) begin
            acc += pascal[j];
            if (acc >= MOD_VALUE) begin
                acc -= MOD_VALUE;
            end
        end
        return acc[SUM_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // result checker
    always @(posedge aclk) begin
        tail_req_t exp_item;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", m_tdata[SUM_W-1:0]));
            end else begin
                exp_item = expected_sums.pop_front();
                if (m_tdata[SUM_W-1:0] !== exp_item.tail_sum) begin
                    report_mismatch($sformatf("n=%0d k=%0d tail_sum got %0d want %0d",
                        exp_item.n_total, exp_item.k_min, m_tdata[SUM_W-1:0],
                        exp_item.tail_sum));
                end
                if (m_tdata[M_DATA_W-1:SUM_W] !== '0) begin
                    report_mismatch($sformatf("n=%0d k=%0d pad bits got %0h",
                        exp_item.n_total, exp_item.k_min, m_tdata[M_DATA_W-1:SUM_W]));
                end
            end
        end
    end

    // send one request, keeping tvalid high into the next one when no gap is drawn
    task automatic send_request(input logic [N_W-1:0] n_total, input logic [K_W-1:0] k_min);
        tail_req_t item;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - N_W - K_W){1'b0}}, k_min, n_total};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        item.n_total  = n_total;
        item.k_min    = k_min;
        item.tail_sum = predict_tail_sum(n_total, k_min);
        expected_sums.push_back(item);
    endtask

    // hold off the sender until every pending sum has come back
    task automatic wait_all_sums();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_sums.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // small rows, empty ranges, whole rows and the first modular wraps
    task automatic test_edge_rows();
        send_request(11'd0, 11'd0);
        send_request(11'd0, 11'd1);
        send_request(11'd0, 11'd2047);
        send_request(11'd1, 11'd0);
        send_request(11'd1, 11'd1);
        send_request(11'd1, 11'd2);
        send_request(11'd2, 11'd1);
        send_request(11'd5, 11'd5);
        send_request(11'd5, 11'd6);
        send_request(11'd30, 11'd0);
        send_request(11'd40, 11'd20);
        send_request(11'd63, 11'd2047);
        send_request(11'd100, 11'd50);
        send_request(11'd100, 11'd100);
        send_request(11'd64, 11'd1024);
    endtask

    // the largest row, summed whole, then an empty range on a small row
    task automatic test_row_max();
        send_request(11'd2047, 11'd0);
        send_request(11'd3, 11'd2047);
    endtask

    // sender stops and waits for the core to drain between requests
    task automatic test_drain_pause();
        send_request(11'd7, 11'd3);
        wait_all_sums();
        send_request(11'd12, 11'd0);
        send_request(11'd12, 11'd13);
        wait_all_sums();
    endtask

    // random rows, mostly small, now and then a larger one
    task automatic test_random_rows(input int count);
        logic [N_W-1:0] n;
        logic [K_W-1:0] k;
        int             pick;
        for (int idx = 0; idx < count; idx++) begin
            if ($urandom_range(31) == 0) begin
                n = N_W'($urandom_range(128, 400));
            end else begin
                n = N_W'($urandom_range(0, 80));
            end
            pick = $urandom_range(7);
            case (pick)
                0: begin
                    k = '0;
                end
                1: begin
                    k = K_W'($urandom_range(n + 1, 2047));
                end
                2: begin
                    k = n;
                end
                3: begin
                    k = K_W'($urandom);
                end
                default: begin
                    k = K_W'($urandom_range(0, n));
                end
            endcase
            send_request(n, k);
        end
    endtask

    // main sequence
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 14;
        dst_idle_pct = 83;
        test_edge_rows();
        test_drain_pause();
        test_random_rows(30);
        wait_all_sums();

        src_idle_pct = 83;
        dst_idle_pct = 14;
        test_row_max();
        test_random_rows(30);
        wait_all_sums();

        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random_rows(30);
        wait_all_sums();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_sums.size() == 0) begin
            $display("PASS binomial_tail_sum_mod_core");
        end else begin
            $display("FAIL binomial_tail_sum_mod_core");
        end
        $finish;
    end

endmodule
